@@ rtl/rcmt_pkg.sv @@
// Shared types and constants for the RGBA color matrix transform.
`default_nettype none
package rcmt_pkg;

  // Pixel and coefficient geometry
  localparam int CHANNELS   = 4;
  localparam int CHAN_W     = 8;
  localparam int GAIN_W     = 12;
  localparam int OFFSET_W   = 16;
  localparam int OFFSET_LSB = 48;
  localparam int ROW_W      = 64;
  localparam int CFG_IDX_W  = 8;

  // Arithmetic widths: product of a Q4.8 gain and a 9-bit signed pixel,
  // and the sum of four products plus the offset scaled to 1/256 units
  localparam int PROD_W = 21;
  localparam int SUM_W  = 23;
  localparam int SUM_MAX = 255 * 256;
  localparam int ROUND_HALF = 128;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_RED   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_GREEN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BLUE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_ALPHA = 8'd3;

  // Identity rows after reset
  localparam logic [ROW_W-1:0] RST_ROW_RED   = 64'd256;
  localparam logic [ROW_W-1:0] RST_ROW_GREEN = 64'd256 << 12;
  localparam logic [ROW_W-1:0] RST_ROW_BLUE  = 64'd256 << 24;
  localparam logic [ROW_W-1:0] RST_ROW_ALPHA = 64'd256 << 36;

  typedef logic [CHANNELS-1:0][CHAN_W-1:0] chan_vec_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;
  } in_pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
  } out_pixel_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [ROW_W-1:0]     wdata;
  } cfg_write_t;

endpackage
`default_nettype wire

@@ rtl/rcmt_if.sv @@
// Stream and configuration channel interfaces for the color matrix transform.
`default_nettype none
interface rcmt_in_if;
  logic                 valid;
  logic                 ready;
  rcmt_pkg::in_pixel_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rcmt_out_if;
  logic                 valid;
  logic                 ready;
  rcmt_pkg::out_pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rcmt_cfg_if;
  logic                 valid;
  logic                 ready;
  rcmt_pkg::cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/rcmt_lane.sv @@
// One output channel: four gain products, offset, clamp and round.
`default_nettype none
module rcmt_lane (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [rcmt_pkg::ROW_W-1:0]          row,
  input  wire rcmt_pkg::chan_vec_t                 px,
  output logic      [rcmt_pkg::CHAN_W-1:0]         res
);

  logic signed [rcmt_pkg::PROD_W-1:0] prod_r   [rcmt_pkg::CHANNELS];
  logic signed [rcmt_pkg::PROD_W-1:0] prod_nxt [rcmt_pkg::CHANNELS];
  logic signed [rcmt_pkg::OFFSET_W-1:0] off_r;
  logic [rcmt_pkg::CHAN_W-1:0] res_r;
  logic [rcmt_pkg::CHAN_W-1:0] res_nxt;

  // Stage 1: one signed multiply per input channel
  always_comb begin
    logic signed [rcmt_pkg::PROD_W-1:0] g_ext;
    logic signed [rcmt_pkg::PROD_W-1:0] p_ext;
    for (int k = 0; k < rcmt_pkg::CHANNELS; k++) begin
      g_ext = rcmt_pkg::PROD_W'($signed(row[k*rcmt_pkg::GAIN_W +: rcmt_pkg::GAIN_W]));
      p_ext = $signed({{(rcmt_pkg::PROD_W-rcmt_pkg::CHAN_W){1'b0}}, px[k]});
      prod_nxt[k] = g_ext * p_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < rcmt_pkg::CHANNELS; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      off_r <= $signed(row[rcmt_pkg::OFFSET_LSB +: rcmt_pkg::OFFSET_W]);
    end
  end

  // Stage 2: sum in 1/256 units, clamp to [0, 255*256], round half up
  always_comb begin
    logic signed [rcmt_pkg::SUM_W-1:0] sum;
    logic [rcmt_pkg::CHAN_W:0]         rnd;
    sum = rcmt_pkg::SUM_W'($signed({off_r, 4'b0000}));
    for (int k = 0; k < rcmt_pkg::CHANNELS; k++) begin
      sum = sum + rcmt_pkg::SUM_W'(prod_r[k]);
    end
    rnd = 9'(({1'b0, sum[15:0]} + 17'(rcmt_pkg::ROUND_HALF)) >> 8);
    if (sum < 0) begin
      res_nxt = '0;
    end else if (sum > rcmt_pkg::SUM_W'(rcmt_pkg::SUM_MAX)) begin
      res_nxt = '1;
    end else begin
      res_nxt = rnd[rcmt_pkg::CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

@@ rtl/rcmt_merge.sv @@
// Gathers the four lane results into one pixel; output register plus skid.
`default_nettype none
module rcmt_merge (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                lane_valid,
  input  wire rcmt_pkg::chan_vec_t lane_res,
  output logic                     accept_ok,
  rcmt_out_if.source               out_ch
);

  rcmt_pkg::out_pixel_t pix_in;
  rcmt_pkg::out_pixel_t out_data_r;
  rcmt_pkg::out_pixel_t skid_data_r;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic out_take;

  // Pack lane bytes into the result item
  assign pix_in.red_out   = lane_res[0];
  assign pix_in.green_out = lane_res[1];
  assign pix_in.blue_out  = lane_res[2];
  assign pix_in.alpha_out = lane_res[3];

  // Output register is free when empty or being taken this cycle
  assign out_take = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_ch.ready) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (out_take) begin
      out_valid_nxt = lane_valid;
    end else if (lane_valid) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload moves
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ch.ready) begin
        out_data_r <= skid_data_r;
      end
    end else if (out_take) begin
      out_data_r <= pix_in;
    end else begin
      skid_data_r <= pix_in;
    end
  end

  // Pipeline may advance only while the skid slot is empty
  assign accept_ok    = !skid_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_ch.ready |=> skid_valid_r && $stable(skid_data_r))
    else $error("skid item lost during stall");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    !skid_valid_r && out_valid_r && !out_ch.ready && lane_valid |=> skid_valid_r)
    else $error("incoming item dropped while output stalled");

endmodule
`default_nettype wire

@@ rtl/rgba_color_matrix_transform_top.sv @@
// Top level of the RGBA color matrix transform: coefficient rows, lanes, merge.
//
// Usage: pixels enter on in_ch (valid/ready, fields red_in..alpha_in) and leave
// on out_ch (red_out..alpha_out). Each output channel is the affine mix
// g_r*R + g_g*G + g_b*B + g_a*A + offset, with Q4.8 gains and a Q12.4 offset,
// clamped to 0..255 and rounded half up. Four lanes, one per output channel,
// work side by side on the same pixel; the merge stage packs their bytes.
// Rows are written on cfg_ch (index 0..3 = red, green, blue, alpha row; other
// indexes are ignored); cfg_ch.ready is always high. Write rows only while no
// pixel is in flight.
// Throughput: one pixel per clock while out_ch.ready is high.
// Latency: three register stages (multiply, sum and clamp, output register);
// an accepted pixel passes the product registers, then the result registers,
// then the output register, which drives out_ch.valid and out_ch.data.
// Stall: an output register and a one-item skid stage absorb back pressure;
// in_ch.ready drops only once the skid is occupied and is driven from a flop.
// Reset (rst_n low, synchronous) empties the pipeline and loads identity rows.
`default_nettype none
module rgba_color_matrix_transform_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rcmt_in_if.sink    in_ch,
  rcmt_out_if.source out_ch,
  rcmt_cfg_if.sink   cfg_ch
);

  logic [rcmt_pkg::ROW_W-1:0] rows_r [rcmt_pkg::CHANNELS];
  rcmt_pkg::chan_vec_t px;
  rcmt_pkg::chan_vec_t lane_res;
  logic en;
  logic v1_r, v2_r;

  // Coefficient row registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[0] <= rcmt_pkg::RST_ROW_RED;
      rows_r[1] <= rcmt_pkg::RST_ROW_GREEN;
      rows_r[2] <= rcmt_pkg::RST_ROW_BLUE;
      rows_r[3] <= rcmt_pkg::RST_ROW_ALPHA;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        rcmt_pkg::REG_ROW_RED:   rows_r[0] <= cfg_ch.data.wdata;
        rcmt_pkg::REG_ROW_GREEN: rows_r[1] <= cfg_ch.data.wdata;
        rcmt_pkg::REG_ROW_BLUE:  rows_r[2] <= cfg_ch.data.wdata;
        rcmt_pkg::REG_ROW_ALPHA: rows_r[3] <= cfg_ch.data.wdata;
        default: ;
      endcase
    end
  end

  // Input pixel as a channel vector
  assign px[0] = in_ch.data.red_in;
  assign px[1] = in_ch.data.green_in;
  assign px[2] = in_ch.data.blue_in;
  assign px[3] = in_ch.data.alpha_in;

  assign in_ch.ready = en;

  // Valid tracking through the two lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
    end
  end

  // One lane per output channel
  for (genvar k = 0; k < rcmt_pkg::CHANNELS; k++) begin : g_lane
    rcmt_lane u_lane (
      .clk (clk),
      .en  (en),
      .row (rows_r[k]),
      .px  (px),
      .res (lane_res[k])
    );
  end

  rcmt_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (v2_r && en),
    .lane_res   (lane_res),
    .accept_ok  (en),
    .out_ch     (out_ch)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted item missing from first stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && en |=> v2_r)
    else $error("item lost between lane stages");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v1_r) && $stable(v2_r))
    else $error("lane stages moved while stalled");

endmodule
`default_nettype wire
